// File: sv/small_key_value_table_defines.svh
// Assertion helpers shared by the table RTL. Each helper expects clk and arst_n in scope.
`ifndef SMALL_KEY_VALUE_TABLE_DEFINES_SVH
`define SMALL_KEY_VALUE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the trigger.
`define SKVT_ASSERT_NOW(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define SKVT_ASSERT_NEXT(label, trig, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error(msg);

`endif

// File: sv/skvt_pkg.sv
package skvt_pkg;

	// Default sizes of the table.
	localparam int DEPTH_DEFAULT      = 16;
	localparam int KEY_BITS_DEFAULT   = 32;
	localparam int VALUE_BITS_DEFAULT = 32;

	// Fixed widths of the transaction fields.
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_UPDATE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t              opcode;
		logic [KEY_W-1:0]     key;
		logic [VALUE_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   read_value;
		logic [COUNT_W-1:0]   entry_count;
	} result_t;

endpackage

// File: sv/skvt_mem.sv
// Simple dual-port table memory: one write port, one read port with registered data.
module skvt_mem #(
	parameter int WIDTH = skvt_pkg::KEY_BITS_DEFAULT + skvt_pkg::VALUE_BITS_DEFAULT,
	parameter int DEPTH = skvt_pkg::DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/small_key_value_table.sv
// Small key/value table. A command transaction (insert, delete, lookup or update) is taken
// when start is high and busy is low; busy then stays high while the table is searched one
// stored entry per clock through the single read port of the table memory, using one shared
// key comparator. A delete that has to move the last entry into the freed slot then goes
// through S_MOVE_RD and S_MOVE_WR. The result appears for exactly one cycle with done high,
// in the same cycle that busy falls, and must be captured then: the receiver cannot stall
// it. A new command may be started in that same cycle. A full table rejects an insert
// before any search, a duplicate key rejects an insert, and a missing key is reported on
// delete, lookup and update. read_value is zero except on a successful lookup, and
// entry_count is the occupancy after the transaction. Keys and values keep only their low
// KEY_BITS and VALUE_BITS bits. There is no clearing pass after reset: only occupied
// entries are compared.
`include "small_key_value_table_defines.svh"

module small_key_value_table #(
	parameter int TABLE_DEPTH = skvt_pkg::DEPTH_DEFAULT,
	parameter int KEY_BITS    = skvt_pkg::KEY_BITS_DEFAULT,
	parameter int VALUE_BITS  = skvt_pkg::VALUE_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  skvt_pkg::cmd_t    cmd,
	output logic              done,
	output skvt_pkg::result_t result
);

	import skvt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = KEY_BITS + VALUE_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR
	} state_t;

	state_t                state_q;
	opcode_t               op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         rd_idx_q;
	logic                  issue_q;
	logic                  cmp_vld_q;
	logic [IW-1:0]         cmp_idx_q;
	logic [IW-1:0]         hit_idx_q;
	logic                  done_q;
	result_t               result_q;

	logic [KEY_BITS-1:0]   key_in;
	logic [VALUE_BITS-1:0] val_in;
	logic [IW-1:0]         last_idx;
	logic                  full;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic [63:0]           rd_val_wide;
	logic                  key_hit;
	logic                  scan_miss;

	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	logic [EW-1:0]         mem_wdata;
	logic [IW-1:0]         mem_raddr;
	logic [EW-1:0]         mem_rdata;

	// Bits above the configured key and value widths are dropped on the way in.
	assign key_in = KEY_BITS'(cmd.key);
	assign val_in = VALUE_BITS'(cmd.value);

	assign last_idx    = IW'(count_q - CW'(1));
	assign full        = (count_q == CW'(TABLE_DEPTH));
	assign rd_key      = mem_rdata[EW-1:VALUE_BITS];
	assign rd_val      = mem_rdata[VALUE_BITS-1:0];
	assign rd_val_wide = 64'(rd_val);

	// The shared comparator: the entry read in the previous cycle against the search key.
	assign key_hit   = cmp_vld_q && (rd_key == key_q);
	// The search ends without a hit on the last occupied entry, or at once on an empty table.
	assign scan_miss = (cmp_vld_q && !key_hit && (cmp_idx_q == last_idx)) ||
		(count_q == CW'(0));

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Memory port control. Reads follow the scan index except when fetching the last entry
	// for a delete; writes come from insert, update and the delete move.
	always_comb begin
		mem_raddr = (state_q == S_MOVE_RD) ? last_idx : rd_idx_q;
		mem_we    = 1'b0;
		mem_waddr = cmp_idx_q;
		mem_wdata = {key_q, val_q};
		case (state_q)
			S_SCAN: begin
				if (op_q == OP_INSERT && full) begin
					mem_we = 1'b0;
				end else if (key_hit && op_q == OP_UPDATE) begin
					mem_we    = 1'b1;
					mem_waddr = cmp_idx_q;
				end else if (!key_hit && scan_miss && op_q == OP_INSERT) begin
					mem_we    = 1'b1;
					mem_waddr = IW'(count_q);
				end
			end
			S_MOVE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = hit_idx_q;
				mem_wdata = mem_rdata;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	skvt_mem #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer. During the search a read is issued every cycle while the entry read in the
	// previous cycle is compared, so the search covers one entry per clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_INSERT;
			key_q     <= '0;
			val_q     <= '0;
			count_q   <= '0;
			rd_idx_q  <= '0;
			issue_q   <= 1'b0;
			cmp_vld_q <= 1'b0;
			cmp_idx_q <= '0;
			hit_idx_q <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= opcode_t'(cmd.opcode);
						key_q     <= key_in;
						val_q     <= val_in;
						rd_idx_q  <= '0;
						issue_q   <= 1'b1;
						cmp_vld_q <= 1'b0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						cmp_vld_q <= 1'b1;
						cmp_idx_q <= rd_idx_q;
						if (rd_idx_q == last_idx) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + IW'(1);
						end
					end else begin
						cmp_vld_q <= 1'b0;
					end

					if (op_q == OP_INSERT && full) begin
						done_q               <= 1'b1;
						result_q.status      <= ST_FULL;
						result_q.read_value  <= '0;
						result_q.entry_count <= COUNT_W'(count_q);
						issue_q              <= 1'b0;
						cmp_vld_q            <= 1'b0;
						state_q              <= S_IDLE;
					end else if (key_hit) begin
						issue_q   <= 1'b0;
						cmp_vld_q <= 1'b0;
						case (op_q)
							OP_INSERT: begin
								done_q               <= 1'b1;
								result_q.status      <= ST_PRESENT;
								result_q.read_value  <= '0;
								result_q.entry_count <= COUNT_W'(count_q);
								state_q              <= S_IDLE;
							end
							OP_LOOKUP: begin
								done_q               <= 1'b1;
								result_q.status      <= ST_OK;
								result_q.read_value  <= rd_val_wide[VALUE_W-1:0];
								result_q.entry_count <= COUNT_W'(count_q);
								state_q              <= S_IDLE;
							end
							OP_UPDATE: begin
								done_q               <= 1'b1;
								result_q.status      <= ST_OK;
								result_q.read_value  <= '0;
								result_q.entry_count <= COUNT_W'(count_q);
								state_q              <= S_IDLE;
							end
							OP_DELETE: begin
								if (cmp_idx_q == last_idx) begin
									// Removing the last entry needs no move.
									count_q              <= count_q - CW'(1);
									done_q               <= 1'b1;
									result_q.status      <= ST_OK;
									result_q.read_value  <= '0;
									result_q.entry_count <= COUNT_W'(count_q - CW'(1));
									state_q              <= S_IDLE;
								end else begin
									hit_idx_q <= cmp_idx_q;
									state_q   <= S_MOVE_RD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end else if (scan_miss) begin
						issue_q             <= 1'b0;
						cmp_vld_q           <= 1'b0;
						done_q              <= 1'b1;
						result_q.read_value <= '0;
						state_q             <= S_IDLE;
						if (op_q == OP_INSERT) begin
							count_q              <= count_q + CW'(1);
							result_q.status      <= ST_OK;
							result_q.entry_count <= COUNT_W'(count_q + CW'(1));
						end else begin
							result_q.status      <= ST_MISSING;
							result_q.entry_count <= COUNT_W'(count_q);
						end
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					count_q              <= count_q - CW'(1);
					done_q               <= 1'b1;
					result_q.status      <= ST_OK;
					result_q.read_value  <= '0;
					result_q.entry_count <= COUNT_W'(count_q - CW'(1));
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted command either finishes at once or keeps the block busy.
	`SKVT_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "command lost")
	// The occupancy never exceeds the table size.
	`SKVT_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(TABLE_DEPTH), "count overflow")
	// The search compares only occupied entries.
	`SKVT_ASSERT_NOW(a_scan_bounds, state_q == S_SCAN && cmp_vld_q,
		CW'(cmp_idx_q) < count_q, "search beyond occupied entries")
	// A successful insert grows the table by exactly one entry.
	`SKVT_ASSERT_NOW(a_insert_count, done && result.status == ST_OK && op_q == OP_INSERT,
		count_q == $past(count_q) + CW'(1), "insert count mismatch")
	// Only a successful operation may return a nonzero value.
	`SKVT_ASSERT_NOW(a_value_zero, done && result.status != ST_OK,
		result.read_value == '0, "value returned on failure")

endmodule
